@@ rtl/thbm_pkg.sv @@
// Package for the tabulation hash bin mapper: constants, item kinds, state codes.
// No dependencies.
package thbm_pkg;
    localparam int NUM_HASH_DEF   = 3;
    localparam int NUM_TABLES_DEF = 8;
    localparam int MAX_BINS_DEF   = 4096;
    localparam int TABLE_ENTRIES  = 256;
    localparam int NB_W           = 13;
    localparam int FILL_W         = 16;
    localparam int WORD_W         = 64;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_HREAD,
        ST_HACC,
        ST_MOD,
        ST_FREAD,
        ST_FWAIT,
        ST_FUPD,
        ST_OUT
    } state_t;
endpackage

@@ rtl/tabulation_hash_bin_mapper_top.sv @@
// Tabulation hash bin mapper top level.
// Depends on thbm_pkg. Holds the table memory, the bin fill memory and the sequencer.
//
// Each word has a kind. A load is taken and the input is ready again on the next
// cycle. A clear walks the bin fill memory, one bin a cycle, so no word is accepted
// until the walk is done; reset starts the same pass with the same wait. An insert
// gives NUM_HASH result words; each function reads NUM_TABLES table words one at a
// time through the single table read port, reduces the hash modulo the bin count
// bit-serially, does a read-modify-write of its bin counter and holds its result
// until taken. An insert keeps the input blocked from acceptance until its last
// result is taken.
module tabulation_hash_bin_mapper_top
    import thbm_pkg::*;
#(
    parameter int NUM_HASH   = NUM_HASH_DEF,
    parameter int NUM_TABLES = NUM_TABLES_DEF,
    parameter int MAX_BINS   = MAX_BINS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [12:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // kind
    input  logic [143:0] s_tdata,   // func_sel[2:0], lut_sel[5:3], byte_sel[13:6],
                                    // table_word[77:14], element[141:78], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast,
    output logic [127:0] m_tdata    // function_id[2:0], bin[14:3], slot[30:15],
                                    // element_index[46:31], tagged_value[110:47],
                                    // max_bin_fill[126:111], zero pad
);
    localparam int HW   = (NUM_HASH > 1) ? $clog2(NUM_HASH) : 1;
    localparam int TW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int BW   = $clog2(MAX_BINS);
    localparam int DEPTH = NUM_HASH * NUM_TABLES * TABLE_ENTRIES;
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] tab_mem [DEPTH];
    logic [FILL_W-1:0] fill_mem [MAX_BINS];

    state_t state_reg, state_next;
    logic [NB_W-1:0]   nb_reg;
    logic [WORD_W-1:0] elem_reg, elem_next;
    logic [HW-1:0]     f_reg, f_next;
    logic [TW:0]       t_reg, t_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [BW:0]       rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [BW-1:0]     bin_reg, bin_next;
    logic [BW:0]       wipe_reg, wipe_next;
    logic [FILL_W-1:0] max_reg, max_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [127:0]      out_reg, out_next;
    logic              last_reg, last_next;

    logic [1:0]  in_kind;
    logic [2:0]  in_f, in_l;
    logic [7:0]  in_b;
    logic [WORD_W-1:0] in_word, in_elem;
    assign in_kind = s_tuser;
    assign in_f    = s_tdata[2:0];
    assign in_l    = s_tdata[5:3];
    assign in_b    = s_tdata[13:6];
    assign in_word = s_tdata[77:14];
    assign in_elem = s_tdata[141:78];

    logic [BW:0] nb_eff;
    always_comb begin
        if (nb_reg == '0) nb_eff = (BW+1)'(1);
        else if ({3'b0, nb_reg} > 16'(MAX_BINS)) nb_eff = (BW+1)'(MAX_BINS);
        else nb_eff = (BW+1)'(nb_reg);
    end

    logic              tab_we, fill_we;
    logic [AW-1:0]     tab_waddr, tab_raddr;
    logic [WORD_W-1:0] tab_rdata;
    logic [BW-1:0]     fill_addr;
    logic [FILL_W-1:0] fill_wdata, fill_rdata;

    always_ff @(posedge aclk) begin
        if (tab_we) tab_mem[tab_waddr] <= in_word;
        tab_rdata <= tab_mem[tab_raddr];
    end
    always_ff @(posedge aclk) begin
        if (fill_we) fill_mem[fill_addr] <= fill_wdata;
        fill_rdata <= fill_mem[fill_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WIPE;
            nb_reg    <= NB_W'(1);
            wipe_reg  <= '0;
            max_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) nb_reg <= cfg_wr_data;
            wipe_reg  <= wipe_next;
            max_reg   <= max_next;
            idx_reg   <= idx_next;
        end
    end
    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
        f_reg    <= f_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        bin_reg  <= bin_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    logic [BW+1:0]     rem_sh;
    logic [FILL_W-1:0] after_fill;
    logic [7:0]        cur_byte;
    assign rem_sh = {rem_reg, acc_reg[WORD_W-1]};
    assign after_fill = (fill_rdata == '1) ? fill_rdata : fill_rdata + 1'b1;
    assign cur_byte = elem_reg[8*t_reg[TW-1:0] +: 8];

    always_comb begin
        state_next = state_reg;
        elem_next = elem_reg; f_next = f_reg; t_next = t_reg; acc_next = acc_reg;
        rem_next = rem_reg; cnt_next = cnt_reg; bin_next = bin_reg;
        wipe_next = wipe_reg; max_next = max_reg;
        idx_next = idx_reg; out_next = out_reg; last_next = last_reg;
        s_tready = 1'b0;
        tab_we = 1'b0;
        tab_waddr = AW'((int'(in_f) * NUM_TABLES + int'(in_l)) * TABLE_ENTRIES + int'(in_b));
        tab_raddr = AW'((int'(f_reg) * NUM_TABLES + int'(t_reg[TW-1:0])) * TABLE_ENTRIES
                        + int'(cur_byte));
        fill_we = 1'b0;
        fill_addr = bin_reg;
        fill_wdata = after_fill;
        unique case (state_reg)
            ST_WIPE: begin
                fill_we = 1'b1;
                fill_addr = wipe_reg[BW-1:0];
                fill_wdata = '0;
                wipe_next = wipe_reg + 1'b1;
                if (wipe_reg == (BW+1)'(MAX_BINS - 1)) begin
                    wipe_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (in_kind)
                        KIND_LOAD: tab_we = (int'(in_f) < NUM_HASH) && (int'(in_l) < NUM_TABLES);
                        KIND_CLEAR: begin
                            max_next = '0;
                            idx_next = '0;
                            state_next = ST_WIPE;
                        end
                        KIND_INSERT: begin
                            elem_next = in_elem;
                            f_next = '0;
                            t_next = '0;
                            acc_next = '0;
                            state_next = ST_HREAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_HREAD: begin
                t_next = t_reg + 1'b1;
                state_next = ST_HACC;
            end
            ST_HACC: begin
                acc_next = acc_reg ^ tab_rdata;
                if (int'(t_reg) == NUM_TABLES) begin
                    rem_next = '0;
                    cnt_next = '0;
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_HREAD;
                end
            end
            ST_MOD: begin
                acc_next = {acc_reg[WORD_W-2:0], 1'b0};
                if (rem_sh >= {1'b0, nb_eff}) rem_next = (BW+1)'(rem_sh - {1'b0, nb_eff});
                else rem_next = rem_sh[BW:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(WORD_W - 1)) state_next = ST_FREAD;
            end
            ST_FREAD: begin
                bin_next = rem_reg[BW-1:0];
                state_next = ST_FWAIT;
            end
            ST_FWAIT: state_next = ST_FUPD;
            ST_FUPD: begin
                fill_we = 1'b1;
                if (after_fill > max_reg) max_next = after_fill;
                out_next = '0;
                out_next[2:0] = 3'(f_reg);
                out_next[14:3] = 12'(bin_reg);
                out_next[30:15] = fill_rdata;
                out_next[46:31] = idx_reg;
                out_next[110:47] = elem_reg ^ WORD_W'(f_reg);
                out_next[126:111] = (after_fill > max_reg) ? after_fill : max_reg;
                last_next = (int'(f_reg) == NUM_HASH - 1);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        idx_next = idx_reg + 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        f_next = f_reg + 1'b1;
                        t_next = '0;
                        acc_next = '0;
                        state_next = ST_HREAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;
endmodule

@@ rtl/thbm_checker.sv @@
// Port-level checker for the tabulation hash bin mapper, bound to the top level.
// Depends on no package: its ports are plain logic, bound by name to the top level's ports.
module thbm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tlast,
    input logic [127:0] m_tdata
);
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");
    a_no_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready) else $error("ready during bin wipe");
    a_first_func: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[2:0] == 3'd0)
        else $error("function order broken");
    a_slot_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:15] < m_tdata[126:111] || m_tdata[30:15] == 16'hffff)
        else $error("slot above largest fill");
endmodule

bind tabulation_hash_bin_mapper_top thbm_checker u_thbm_checker (.*);

@@ bench/tb_top.sv @@
// Testbench for tabulation_hash_bin_mapper_top: table loads, clears, inserts and ignored
// words on the input stream, placements checked against a predictor built into this file.
// Depends on thbm_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
    import thbm_pkg::*;

    localparam int NHASH = 3;
    localparam int NTAB = 8;
    localparam int NBINS = 4096;

    typedef struct packed {
        logic [2:0]  fid;
        logic [11:0] bin;
        logic [15:0] slot;
        logic [15:0] eidx;
        logic [63:0] tval;
        logic [15:0] maxfill;
        logic        last;
    } placement_t;

    typedef struct {
        kind_t       kind;
        logic [2:0]  fsel;
        logic [2:0]  lsel;
        logic [7:0]  bsel;
        logic [63:0] word;
        logic [63:0] elem;
        bit          typed;
        logic [11:0] bin0;
        logic [15:0] slot0;
    } stim_row_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic [12:0]  cfg_wr_data = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [1:0]   s_tuser = 0;
    logic [143:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic         m_tlast;
    logic [127:0] m_tdata;

    tabulation_hash_bin_mapper_top dut (.*);

    always #1 aclk = ~aclk;

    logic [63:0] hash_mem [NHASH][NTAB][256];
    logic [15:0] fill_mem [NBINS];
    logic [15:0] top_fill;
    logic [15:0] elem_count;
    logic [12:0] bin_count;
    placement_t  pending_placements [$];
    int          mismatches = 0;
    int          placements_seen = 0;
    int          inserts_sent = 0;
    bit          calm = 0;
    bit          seen_words [NHASH][NTAB][256];

    function automatic int bins_used();
        if (bin_count == 0) return 1;
        if (bin_count > NBINS) return NBINS;
        return int'(bin_count);
    endfunction

    task automatic predict_word(input kind_t k, input logic [2:0] fs, input logic [2:0] ls,
                                input logic [7:0] bs, input logic [63:0] w,
                                input logic [63:0] e);
        logic [63:0] acc;
        int          b;
        placement_t  p;
        case (k)
            KIND_LOAD: begin
                if (fs < NHASH) begin
                    hash_mem[fs][ls][bs] = w;
                    seen_words[fs][ls][bs] = 1;
                end
            end
            KIND_CLEAR: begin
                foreach (fill_mem[i]) fill_mem[i] = 0;
                top_fill = 0;
                elem_count = 0;
            end
            KIND_INSERT: begin
                for (int f = 0; f < NHASH; f++) begin
                    acc = 0;
                    for (int t = 0; t < NTAB; t++) acc ^= hash_mem[f][t][e[8*t +: 8]];
                    b = int'(acc % 64'(bins_used()));
                    p.fid = 3'(f);
                    p.bin = 12'(b);
                    p.slot = fill_mem[b];
                    if (fill_mem[b] != 16'hFFFF) fill_mem[b]++;
                    if (fill_mem[b] > top_fill) top_fill = fill_mem[b];
                    p.eidx = elem_count;
                    p.tval = e ^ 64'(f);
                    p.maxfill = top_fill;
                    p.last = (f == NHASH - 1);
                    pending_placements.insert(pending_placements.size(), p);
                end
                elem_count++;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input kind_t k, input logic [2:0] fs, input logic [2:0] ls,
                             input logic [7:0] bs, input logic [63:0] w,
                             input logic [63:0] e);
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        predict_word(k, fs, ls, bs, w, e);
        if (k == KIND_INSERT) inserts_sent++;
        s_tvalid <= 1;
        s_tuser <= k;
        s_tdata <= {2'b0, e, w, bs, ls, fs};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop the valid after the last word of a burst
    task automatic stop_input();
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain_and_config(input logic [12:0] nb);
        stop_input();
        while (pending_placements.size() != 0 || !s_tready) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= nb;
        @(posedge aclk);
        cfg_wr_en <= 0;
        bin_count = nb;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // element whose bytes only address loaded table words
    function automatic logic [63:0] legal_element();
        logic [63:0] e;
        for (int t = 0; t < NTAB; t++) begin
            do e[8*t +: 8] = 8'($urandom_range(255));
            while (!(seen_words[0][t][e[8*t +: 8]] && seen_words[1][t][e[8*t +: 8]]
                     && seen_words[2][t][e[8*t +: 8]]));
        end
        return e;
    endfunction

    always @(posedge aclk) begin
        if (!calm) m_tready <= ($urandom_range(99) >= 29);
        else m_tready <= 1;
        if (m_tvalid && m_tready) begin
            placement_t got, want;
            got = '{m_tdata[2:0], m_tdata[14:3], m_tdata[30:15], m_tdata[46:31],
                    m_tdata[110:47], m_tdata[126:111], m_tlast};
            placements_seen++;
            if (pending_placements.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected placement %p", got);
            end else begin
                want = pending_placements.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("placement: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        stim_row_t rows [8];
        stim_row_t r;
        logic [2:0] fs;
        logic [7:0] bs;
        foreach (fill_mem[i]) fill_mem[i] = 0;
        top_fill = 0;
        elem_count = 0;
        bin_count = 1;
        repeat (2) @(posedge aclk);
        aresetn <= 1;

        // zero every entry at byte 0 and all-ones at byte 255, so extremes hash known
        for (int f = 0; f < NHASH; f++)
            for (int t = 0; t < NTAB; t++) begin
                send_word(KIND_LOAD, 3'(f), 3'(t), 8'd0, 64'd0, 64'd0);
                send_word(KIND_LOAD, 3'(f), 3'(t), 8'hFF, '1, 64'd0);
            end
        // directed table: one bin, zero element, all-ones element, ignored words, a clear
        rows[0] = '{KIND_INSERT, 0, 0, 0, 0, 64'd0, 1, 12'd0, 16'd0};
        rows[1] = '{KIND_INSERT, 0, 0, 0, 0, '1, 1, 12'd0, 16'd3};
        rows[2] = '{KIND_LOAD, 3'd7, 3'd7, 8'd0, '1, 0, 0, 0, 0};
        rows[3] = '{KIND_LOAD, 3'd3, 3'd0, 8'd0, '1, 0, 0, 0, 0};
        rows[4] = '{KIND_NONE, 3'd7, 3'd7, 8'hFF, '1, '1, 0, 0, 0};
        rows[5] = '{KIND_INSERT, 0, 0, 0, 0, 64'd0, 1, 12'd0, 16'd6};
        rows[6] = '{KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0};
        rows[7] = '{KIND_INSERT, 0, 0, 0, 0, 64'd0, 1, 12'd0, 16'd0};
        foreach (rows[i]) begin
            r = rows[i];
            if (r.typed) begin
                stop_input();
                while (pending_placements.size() != 0) @(posedge aclk);
                send_word(r.kind, r.fsel, r.lsel, r.bsel, r.word, r.elem);
                if (pending_placements[0].bin !== r.bin0 || pending_placements[0].slot !== r.slot0)
                    begin
                    mismatches++;
                    $display("directed row %0d: predictor disagrees with table", i);
                end
            end else send_word(r.kind, r.fsel, r.lsel, r.bsel, r.word, r.elem);
        end

        // fill the tables at random, then insert, with some loads, clears and ignored words, under several bin counts
        for (int t = 0; t < NTAB; t++)
            for (int b = 1; b < 255; b += 16 + $urandom_range(32))
                for (int f = 0; f < NHASH; f++)
                    send_word(KIND_LOAD, 3'(f), 3'(t), 8'(b), rand64(), 0);
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: drain_and_config(13'd0);
                1: drain_and_config(13'd4096);
                2: drain_and_config(13'h1FFF);
                3: drain_and_config(13'($urandom_range(2, 64)));
                4: drain_and_config(13'd1);
                default: drain_and_config(13'($urandom_range(1, 4095)));
            endcase
            calm = (phase == 4);
            for (int n = 0; n < 30; n++) begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 80)
                    send_word(KIND_INSERT, 3'($urandom), 0, 0, rand64(), legal_element());
                else if (pick < 88) begin
                    fs = 3'($urandom_range(7));
                    bs = 8'($urandom_range(255));
                    send_word(KIND_LOAD, fs, 3'($urandom_range(7)), bs, rand64(), 0);
                end else if (pick < 93)
                    send_word(KIND_CLEAR, 3'($urandom), 0, 0, rand64(), rand64());
                else send_word(KIND_NONE, 3'($urandom), 3'($urandom), 8'($urandom), rand64(),
                               rand64());
                if (n == 15) begin
                    stop_input();
                    while (pending_placements.size() != 0) @(posedge aclk);
                end
            end
            calm = 0;
        end

        stop_input();
        while (pending_placements.size() != 0 || !s_tready) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Inserted %0d elements across six bin counts, %0d placements compared.",
                 inserts_sent, placements_seen);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
